### hdl/dzpc_pkg.sv
// Shared constants, register codes and interface types of the dead zone power curve.
package dzpc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_W    = 23;
  localparam int OUT_W      = 17;
  localparam int DZ_W       = 12;
  localparam int SPAN_W     = 16;
  localparam int EXP_W      = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int MAG_W  = ANGLE_W;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int REM_W  = SPAN_W + 1;
  localparam int PROD_W = SPAN_W + T_W;
  localparam int RES_W  = OUT_W + 1;
  localparam int CNT_W  = ($clog2(FRAC_BITS) > EXP_W) ? $clog2(FRAC_BITS) : EXP_W;

  localparam logic [SPAN_W-1:0] MIN_SPAN = SPAN_W'(26);
  localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_EN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SPAN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SPAN   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = CFG_IDX_W'(5);

  localparam logic [DZ_W-1:0]   RST_DEAD_ZONE  = DZ_W'(512);
  localparam logic [SPAN_W-1:0] RST_INPUT_SPAN = SPAN_W'(11520);
  localparam logic [SPAN_W-1:0] RST_OUT_SPAN   = SPAN_W'(23040);
  localparam logic [EXP_W-1:0]  RST_EXPONENT   = EXP_W'(15);

  typedef struct packed {
    logic              axis_en;
    logic              invert;
    logic [DZ_W-1:0]   dead_zone;
    logic [SPAN_W-1:0] input_span;
    logic [SPAN_W-1:0] output_span;
    logic [EXP_W-1:0]  exponent;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic pow_step;
    logic scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic dead;
    logic sat;
  } stat_t;

endpackage

### hdl/dzpc_regs.sv
// Configuration register file of the dead zone power curve.
module dzpc_regs
  import dzpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_en     <= 1'b1;
      cfg.invert      <= 1'b0;
      cfg.dead_zone   <= RST_DEAD_ZONE;
      cfg.input_span  <= RST_INPUT_SPAN;
      cfg.output_span <= RST_OUT_SPAN;
      cfg.exponent    <= RST_EXPONENT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_EN:    cfg.axis_en     <= cfg_data[0];
        REG_INVERT:     cfg.invert      <= cfg_data[0];
        REG_DEAD_ZONE:  cfg.dead_zone   <= cfg_data[DZ_W-1:0];
        REG_INPUT_SPAN: cfg.input_span  <= cfg_data[SPAN_W-1:0];
        REG_OUT_SPAN:   cfg.output_span <= cfg_data[SPAN_W-1:0];
        REG_EXPONENT:   cfg.exponent    <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/dzpc_ctrl.sv
// Sequencing state machine: check, divide, power loop, scale, finish.
module dzpc_ctrl
  import dzpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  cfg_t  cfg,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_POW    = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] n_eff;

  assign n_eff = (cfg.exponent == '0) ? CNT_W'(1) : CNT_W'(cfg.exponent);
  assign busy  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.prep = 1'b1;
        if (stat.dead) begin
          state_next = S_FINISH;
        end else if (stat.sat) begin
          state_next = S_POW;
          cnt_next   = CNT_W'(1);
        end else begin
          state_next = S_DIV;
          cnt_next   = '0;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          state_next = S_POW;
          cnt_next   = CNT_W'(1);
        end
      end
      S_POW: begin
        if (cnt < n_eff) begin
          cmd.pow_step = 1'b1;
          cnt_next     = cnt + CNT_W'(1);
        end else begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### hdl/dzpc_dp.sv
// Datapath: magnitude and dead zone check, restoring divider, power multiplier, output scaling.
module dzpc_dp
  import dzpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  input  logic signed [ANGLE_W-1:0] angle_in,
  output stat_t                     stat,
  output logic signed [OUT_W-1:0]   angle_out,
  output logic                      in_dead_zone,
  output logic                      done
);

  logic signed [ANGLE_W-1:0] angle_q;
  logic [REM_W-1:0]          rem;
  logic [SPAN_W-1:0]         span_q;
  logic [T_W-1:0]            t;
  logic [T_W-1:0]            p;
  logic                      dead_q;
  logic                      neg_q;
  logic [PROD_W-1:0]         prod_q;

  logic signed [ANGLE_W:0]   a_ext;
  logic [ANGLE_W:0]          a_neg;
  logic [MAG_W-1:0]          mag;
  logic                      positive;
  logic [SPAN_W-1:0]         dz_min;
  logic [SPAN_W-1:0]         top;
  logic [SPAN_W-1:0]         span;
  logic [MAG_W-1:0]          excess;
  logic [REM_W-1:0]          r2;
  logic                      ge;
  logic [2*T_W-1:0]          pmul;
  logic [SPAN_W:0]           diff;
  logic                      diff_neg;
  logic [SPAN_W-1:0]         absdiff;
  logic [PROD_W-FRAC_BITS-1:0] scaled;
  logic [RES_W-1:0]          mag_res;
  logic [RES_W-1:0]          res;

  assign a_ext    = {angle_q[ANGLE_W-1], angle_q};
  assign a_neg    = (ANGLE_W+1)'(0) - a_ext;
  assign mag      = angle_q[ANGLE_W-1] ? a_neg[MAG_W-1:0] : angle_q[MAG_W-1:0];
  assign positive = !angle_q[ANGLE_W-1] && (angle_q != '0);

  assign dz_min = SPAN_W'(cfg.dead_zone) + MIN_SPAN;
  assign top    = (cfg.input_span > dz_min) ? cfg.input_span : dz_min;
  assign span   = top - SPAN_W'(cfg.dead_zone);
  assign excess = mag - MAG_W'(cfg.dead_zone);

  assign stat.dead = !cfg.axis_en || (mag < MAG_W'(cfg.dead_zone));
  assign stat.sat  = excess >= MAG_W'(span);

  // one quotient bit per step
  assign r2 = {rem[SPAN_W-1:0], 1'b0};
  assign ge = r2 >= {1'b0, span_q};

  assign pmul = p * t;

  assign diff     = {1'b0, cfg.output_span} - (SPAN_W+1)'(cfg.dead_zone);
  assign diff_neg = diff[SPAN_W];
  assign absdiff  = diff_neg ? SPAN_W'((SPAN_W+1)'(0) - diff) : diff[SPAN_W-1:0];

  assign scaled  = prod_q[PROD_W-1:FRAC_BITS];
  assign mag_res = diff_neg ? (RES_W'(cfg.dead_zone) - RES_W'(scaled))
                            : (RES_W'(cfg.dead_zone) + RES_W'(scaled));
  assign res     = (neg_q ^ cfg.invert) ? (RES_W'(0) - mag_res) : mag_res;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_q <= angle_in;
    end
    if (cmd.prep) begin
      dead_q <= stat.dead;
      neg_q  <= !positive;
      span_q <= span;
      rem    <= REM_W'(excess[SPAN_W-1:0]);
      t      <= stat.sat ? T_ONE : '0;
      p      <= stat.sat ? T_ONE : '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? (r2 - {1'b0, span_q}) : r2;
      t   <= {t[T_W-2:0], ge};
      p   <= {p[T_W-2:0], ge};
    end
    if (cmd.pow_step) begin
      p <= pmul[FRAC_BITS +: T_W];
    end
    if (cmd.scale) begin
      prod_q <= PROD_W'(absdiff) * PROD_W'(p);
    end
    if (cmd.finish) begin
      angle_out    <= dead_q ? '0 : res[OUT_W-1:0];
      in_dead_zone <= dead_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

### hdl/deadzone_power_curve.sv
// Top level of the dead zone power curve: register file, controller and datapath.
//
// Usage: raise start with angle_in while busy is low; the request is taken at that edge
// and busy stays high until the result is out. The result appears on angle_out and
// in_dead_zone, marked by done for exactly one cycle; the receiver cannot stall it,
// and busy is already low in the done cycle, so the next request may be taken then.
// From the accepting edge to the edge that raises done, the controller steps through:
//   disabled or inside the dead zone:     check, finish
//   beyond the input span (t = one):      check, power loop, scale, finish
//   otherwise:                            check, divider, power loop, scale, finish
// where the power loop raises t to the power n, the exponent register (0 counts as 1).
// The restoring divider yields one quotient bit per cycle and the power loop does one
// multiply per cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index on the rising clock edge; indexes
// beyond the list are ignored. Write only while busy is low.
// Reset (rst, synchronous) restores the register defaults and returns to idle.
module deadzone_power_curve
  import dzpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle_in,
  output logic                      done,
  output logic signed [OUT_W-1:0]   angle_out,
  output logic                      in_dead_zone,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  dzpc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dzpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cfg   (cfg),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dzpc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .angle_in     (angle_in),
    .stat         (stat),
    .angle_out    (angle_out),
    .in_dead_zone (in_dead_zone),
    .done         (done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    (done && in_dead_zone) |-> (angle_out == '0))
    else $error("dead zone result is not zero");

endmodule

### bench/tb.sv
// Self-checking testbench for the dead zone power curve block.
`timescale 1ns / 100ps

module tb;
  import dzpc_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] angle;
    logic                    dead;
  } shaped_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [ANGLE_W-1:0] angle_in;
  logic                      done;
  logic signed [OUT_W-1:0]   angle_out;
  logic                      in_dead_zone;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // Shadow copy of the register file.
  logic              axis_en_q;
  logic              invert_q;
  logic [DZ_W-1:0]   dead_zone_q;
  logic [SPAN_W-1:0] input_span_q;
  logic [SPAN_W-1:0] output_span_q;
  logic [EXP_W-1:0]  exponent_q;

  shaped_t pending_shapes[$];
  bit      idle_on;
  int      err_count;
  int      mismatch_count;
  int      checked_count;
  int      dead_count;
  int      setting_count;

  deadzone_power_curve dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .angle_in     (angle_in),
    .done         (done),
    .angle_out    (angle_out),
    .in_dead_zone (in_dead_zone),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic shaped_t shape_angle(input logic [ANGLE_W-1:0] a);
    logic              neg;
    logic              pos;
    logic [23:0]       mag;
    logic [23:0]       excess;
    logic [16:0]       top;
    logic [16:0]       span;
    logic [63:0]       t;
    logic [63:0]       p;
    logic signed [63:0] scaled;
    logic signed [63:0] res;
    int                n;
    int                i;
    shaped_t           r;
    neg = a[ANGLE_W-1];
    mag = neg ? (24'h800000 - {1'b0, a}) : {1'b0, a};
    pos = !neg && (a != '0);
    if (!axis_en_q || mag < 24'(dead_zone_q)) begin
      r.angle = '0;
      r.dead  = 1'b1;
      return r;
    end
    top = 17'(dead_zone_q) + 17'(MIN_SPAN);
    if (17'(input_span_q) > top) top = 17'(input_span_q);
    span   = top - 17'(dead_zone_q);
    excess = mag - 24'(dead_zone_q);
    if (excess >= 24'(span)) t = 64'd1 << FRAC_BITS;
    else t = (64'(excess) << FRAC_BITS) / 64'(span);
    n = (exponent_q == '0) ? 1 : int'(exponent_q);
    p = t;
    for (i = 1; i < n; i++) p = (p * t) >> FRAC_BITS;
    if (output_span_q >= 16'(dead_zone_q))
      scaled = $signed((64'(output_span_q - 16'(dead_zone_q)) * p) >> FRAC_BITS);
    else
      scaled = -$signed((64'(16'(dead_zone_q) - output_span_q) * p) >> FRAC_BITS);
    res = $signed(64'(dead_zone_q)) + scaled;
    if (!pos) res = -res;
    if (invert_q) res = -res;
    r.angle = res[OUT_W-1:0];
    r.dead  = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    shaped_t want;
    if (!rst && done) begin
      if (pending_shapes.size() == 0) begin
        err_count++;
        $display("ERROR: result with no request waiting: angle_out=%0d in_dead_zone=%0b",
                 angle_out, in_dead_zone);
      end else begin
        want = pending_shapes.pop_front();
        checked_count++;
        if (want.dead) dead_count++;
        if (angle_out !== want.angle || in_dead_zone !== want.dead) begin
          err_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: angle_out %0d/%0d in_dead_zone %0b/%0b (exp/act)",
                     want.angle, angle_out, want.dead, in_dead_zone);
        end
      end
    end
  end

  task automatic request_angle(input logic [ANGLE_W-1:0] a);
    int  gap;
    bit  taken;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    angle_in <= a;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    pending_shapes.push_back(shape_angle(a));
  endtask

  task automatic wait_idle();
    @(negedge clk) start <= 1'b0;
    while (pending_shapes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_AXIS_EN:    axis_en_q     = val[0];
      REG_INVERT:     invert_q      = val[0];
      REG_DEAD_ZONE:  dead_zone_q   = val[DZ_W-1:0];
      REG_INPUT_SPAN: input_span_q  = val;
      REG_OUT_SPAN:   output_span_q = val;
      REG_EXPONENT:   exponent_q    = val[EXP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(input logic en, input logic inv, input int dz,
                               input int ispan, input int ospan, input int n);
    write_reg(REG_AXIS_EN, CFG_DATA_W'(en));
    write_reg(REG_INVERT, CFG_DATA_W'(inv));
    write_reg(REG_DEAD_ZONE, CFG_DATA_W'(dz));
    write_reg(REG_INPUT_SPAN, CFG_DATA_W'(ispan));
    write_reg(REG_OUT_SPAN, CFG_DATA_W'(ospan));
    write_reg(REG_EXPONENT, CFG_DATA_W'(n));
    setting_count++;
  endtask

  function automatic int unsigned pick_span();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m == 0) return 0;
    if (m == 1) return 16'hFFFF;
    if (m == 2) return 46080;
    return $urandom_range(0, 46080);
  endfunction

  task automatic apply_random_setting();
    int unsigned m;
    int unsigned dz;
    int unsigned n;
    m = $urandom_range(0, 9);
    dz = (m == 0) ? 0 : (m == 1) ? 12'hFFF : $urandom_range(0, 3840);
    m = $urandom_range(0, 9);
    n = (m == 0) ? 0 : (m == 1) ? 63 : (m == 2) ? $urandom_range(41, 63) : $urandom_range(1, 40);
    // upper data bits beyond the narrower registers' widths carry random junk
    write_reg(REG_AXIS_EN, {15'($urandom_range(0, 16'h7FFF)), ($urandom_range(0, 9) != 0)});
    write_reg(REG_INVERT, CFG_DATA_W'($urandom));
    write_reg(REG_DEAD_ZONE, {4'($urandom), 12'(dz)});
    write_reg(REG_INPUT_SPAN, CFG_DATA_W'(pick_span()));
    write_reg(REG_OUT_SPAN, CFG_DATA_W'(pick_span()));
    write_reg(REG_EXPONENT, {10'($urandom), 6'(n)});
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(6, 7)), CFG_DATA_W'($urandom));
    setting_count++;
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    int unsigned       m;
    int unsigned       top;
    int unsigned       mag;
    logic [ANGLE_W-1:0] v;
    m = $urandom_range(0, 19);
    top = (input_span_q > dead_zone_q + 26) ? input_span_q : dead_zone_q + 26;
    if (m < 4) return ANGLE_W'($urandom);
    if (m < 7) begin
      mag = dead_zone_q + $urandom_range(0, 6);
      mag = (mag >= 3) ? mag - 3 : 0;
    end else begin
      mag = $urandom_range(0, top + top / 4);
    end
    v = ANGLE_W'(mag);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic test_reset_values();
    wait_idle();
    request_angle(ANGLE_W'(0));
    request_angle(ANGLE_W'(511));
    request_angle(ANGLE_W'(512));
    request_angle(-ANGLE_W'(513));
    request_angle(ANGLE_W'(6000));
    request_angle(ANGLE_W'(11520));
    request_angle(-ANGLE_W'(11519));
    request_angle(ANGLE_W'(2560000));
    request_angle(23'h3FFFFF);
    request_angle(23'h400000);
  endtask

  task automatic test_disable_invert();
    wait_idle();
    write_setting(1'b0, 1'b0, 512, 11520, 23040, 15);
    request_angle(ANGLE_W'(5000));
    request_angle(-ANGLE_W'(5000));
    wait_idle();
    write_setting(1'b1, 1'b1, 512, 11520, 23040, 15);
    request_angle(ANGLE_W'(5000));
    request_angle(-ANGLE_W'(5000));
  endtask

  task automatic test_zero_dead_zone();
    // zero angle outside an empty dead zone, minimum span, exponent zero
    wait_idle();
    write_setting(1'b1, 1'b0, 0, 0, 23040, 0);
    request_angle(ANGLE_W'(0));
    request_angle(ANGLE_W'(13));
    request_angle(-ANGLE_W'(13));
    request_angle(ANGLE_W'(26));
  endtask

  task automatic test_span_extremes();
    // output span under the dead zone: curve falls, largest exponent; then inverted, largest output span
    wait_idle();
    write_setting(1'b1, 1'b0, 4095, 16'hFFFF, 100, 63);
    request_angle(ANGLE_W'(4095));
    request_angle(ANGLE_W'(30000));
    request_angle(-ANGLE_W'(65535));
    wait_idle();
    write_setting(1'b1, 1'b1, 0, 46080, 16'hFFFF, 40);
    request_angle(ANGLE_W'(23040));
    request_angle(-ANGLE_W'(46080));
  endtask

  task automatic test_random_settings();
    int ph;
    int k;
    for (ph = 0; ph < 10; ph++) begin
      wait_idle();
      idle_on = (ph < 8);
      apply_random_setting();
      for (k = 0; k < 65; k++) request_angle(random_angle());
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    angle_in  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    axis_en_q     = 1'b1;
    invert_q      = 1'b0;
    dead_zone_q   = RST_DEAD_ZONE;
    input_span_q  = RST_INPUT_SPAN;
    output_span_q = RST_OUT_SPAN;
    exponent_q    = RST_EXPONENT;
    idle_on        = 1'b1;
    err_count      = 0;
    mismatch_count = 0;
    checked_count  = 0;
    dead_count     = 0;
    setting_count  = 1;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_values();
    test_disable_invert();
    test_zero_dead_zone();
    test_span_extremes();
    test_random_settings();

    wait_idle();
    repeat (100) @(posedge clk);
    if (pending_shapes.size() != 0) begin
      err_count++;
      $display("ERROR: %0d requests never answered", pending_shapes.size());
    end
    $display("Checked %0d results over %0d register settings, %0d zeroed by dead zone or disable",
             checked_count, setting_count, dead_count);
    $display("%0d mismatches, %0d errors in total", mismatch_count, err_count);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
